@@ design/dsf_pkg.sv @@
// package for the damped spring force block: widths, register codes, word types
// no dependencies; used by the interfaces and the top module
package dsf_pkg;

	localparam int FRAC_BITS  = 16;
	localparam int POS_W      = 32;
	localparam int DIFF_W     = POS_W + 1;
	localparam int REG_W      = 31;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 32;

	typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

	localparam cfg_idx_t IDX_STIFFNESS   = cfg_idx_t'(0);
	localparam cfg_idx_t IDX_REST_LENGTH = cfg_idx_t'(1);
	localparam cfg_idx_t IDX_DAMPING     = cfg_idx_t'(2);

	localparam logic [REG_W-1:0] RST_STIFFNESS   = REG_W'(65536);
	localparam logic [REG_W-1:0] RST_REST_LENGTH = REG_W'(65536);
	localparam logic [REG_W-1:0] RST_DAMPING     = REG_W'(0);

	typedef struct packed {
		logic signed [POS_W-1:0] a_pos_x;
		logic signed [POS_W-1:0] a_pos_y;
		logic signed [POS_W-1:0] a_vel_x;
		logic signed [POS_W-1:0] a_vel_y;
		logic signed [POS_W-1:0] b_pos_x;
		logic signed [POS_W-1:0] b_pos_y;
		logic signed [POS_W-1:0] b_vel_x;
		logic signed [POS_W-1:0] b_vel_y;
	} item_t;

	typedef struct packed {
		logic signed [POS_W-1:0] force_x;
		logic signed [POS_W-1:0] force_y;
		logic [POS_W-1:0]        potential_energy;
		logic                    coincident;
	} result_t;

endpackage

@@ design/dsf_if.sv @@
// valid/ready channel interfaces for the damped spring force block
// depends on dsf_pkg for the word types
interface dsf_item_if;
	logic            valid;
	logic            ready;
	dsf_pkg::item_t  data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dsf_result_if;
	logic             valid;
	logic             ready;
	dsf_pkg::result_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface dsf_cfg_if;
	logic                               valid;
	logic                               ready;
	dsf_pkg::cfg_idx_t                  index;
	logic [dsf_pkg::CFG_DATA_W-1:0]     data;
	modport source (output valid, output index, output data, input ready);
	modport sink (input valid, input index, input data, output ready);
endinterface

@@ design/dsf_dly.sv @@
// enabled delay line that keeps side data aligned with the pipeline
// no package dependency
module dsf_dly #(
	parameter int W = 1,
	parameter int N = 1
) (
	input  logic         clk,
	input  logic         en,
	input  logic [W-1:0] d,
	output logic [W-1:0] q
);

	logic [W-1:0] line_q [N];

	always_ff @(posedge clk) begin
		if (en) begin
			line_q[0] <= d;
			for (int i = 1; i < N; i++) begin
				line_q[i] <= line_q[i-1];
			end
		end
	end

	assign q = line_q[N-1];

endmodule

@@ design/dsf_mul.sv @@
// two-stage unsigned multiplier, b split into two halves
// no package dependency
module dsf_mul #(
	parameter int AW = 32,
	parameter int BW = 32
) (
	input  logic            clk,
	input  logic            en,
	input  logic [AW-1:0]   a,
	input  logic [BW-1:0]   b,
	output logic [AW+BW-1:0] p
);

	localparam int BL = (BW + 1) / 2;
	localparam int BH = BW - BL;

	logic [AW+BL-1:0] lo_s1;
	logic [AW+BH-1:0] hi_s1;
	logic [AW+BW-1:0] p_s2;

	always_ff @(posedge clk) begin
		if (en) begin
			lo_s1 <= (AW+BL)'(a) * (AW+BL)'(b[BL-1:0]);
			hi_s1 <= (AW+BH)'(a) * (AW+BH)'(b[BW-1:BL]);
			p_s2  <= (AW+BW)'(lo_s1) + ((AW+BW)'(hi_s1) << BL);
		end
	end

	assign p = p_s2;

endmodule

@@ design/dsf_sqrt.sv @@
// pipelined integer square root, one root bit per stage
// no package dependency
module dsf_sqrt #(
	parameter int RAD_W = 66
) (
	input  logic                 clk,
	input  logic                 en,
	input  logic [RAD_W-1:0]     rad,
	output logic [RAD_W/2-1:0]   root
);

	localparam int ROOT_W = RAD_W / 2;
	localparam int REM_W  = ROOT_W + 2;

	logic [RAD_W-1:0]  rad_q  [ROOT_W];
	logic [REM_W-1:0]  rem_q  [ROOT_W];
	logic [ROOT_W-1:0] root_q [ROOT_W];

	logic [RAD_W-1:0]  src_rad  [ROOT_W];
	logic [REM_W-1:0]  src_rem  [ROOT_W];
	logic [ROOT_W-1:0] src_root [ROOT_W];

	logic [RAD_W-1:0]  nxt_rad  [ROOT_W];
	logic [REM_W-1:0]  nxt_rem  [ROOT_W];
	logic [ROOT_W-1:0] nxt_root [ROOT_W];

	logic [REM_W+1:0] rem_sh;
	logic [REM_W+1:0] trial;
	logic [REM_W+1:0] diff;

	always_comb begin
		src_rad[0]  = rad;
		src_rem[0]  = '0;
		src_root[0] = '0;
		for (int i = 1; i < ROOT_W; i++) begin
			src_rad[i]  = rad_q[i-1];
			src_rem[i]  = rem_q[i-1];
			src_root[i] = root_q[i-1];
		end
		for (int i = 0; i < ROOT_W; i++) begin
			// bring down the next bit pair, try root*4+1
			rem_sh = {src_rem[i], src_rad[i][RAD_W-1 -: 2]};
			trial  = {2'b00, src_root[i], 2'b01};
			diff   = rem_sh - trial;
			if (rem_sh >= trial) begin
				nxt_rem[i]  = diff[REM_W-1:0];
				nxt_root[i] = {src_root[i][ROOT_W-2:0], 1'b1};
			end else begin
				nxt_rem[i]  = rem_sh[REM_W-1:0];
				nxt_root[i] = {src_root[i][ROOT_W-2:0], 1'b0};
			end
			nxt_rad[i] = src_rad[i] << 2;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < ROOT_W; i++) begin
				rad_q[i]  <= nxt_rad[i];
				rem_q[i]  <= nxt_rem[i];
				root_q[i] <= nxt_root[i];
			end
		end
	end

	assign root = root_q[ROOT_W-1];

endmodule

@@ design/dsf_div.sv @@
// pipelined restoring divider for num*2^(Q_W-1)/den with num <= den
// no package dependency
module dsf_div #(
	parameter int NUM_W = 33,
	parameter int Q_W   = 17
) (
	input  logic             clk,
	input  logic             en,
	input  logic [NUM_W-1:0] num,
	input  logic [NUM_W-1:0] den,
	output logic [Q_W-1:0]   quo
);

	logic [NUM_W:0]   rem_q [Q_W];
	logic [NUM_W-1:0] den_q [Q_W];
	logic [Q_W-1:0]   quo_q [Q_W];

	logic [NUM_W:0]   src_rem [Q_W];
	logic [NUM_W-1:0] src_den [Q_W];
	logic [Q_W-1:0]   src_quo [Q_W];

	logic [NUM_W:0]   nxt_rem [Q_W];
	logic [Q_W-1:0]   nxt_quo [Q_W];

	logic           take;
	logic [NUM_W:0] diff;

	always_comb begin
		src_rem[0] = {1'b0, num};
		src_den[0] = den;
		src_quo[0] = '0;
		for (int i = 1; i < Q_W; i++) begin
			src_rem[i] = rem_q[i-1];
			src_den[i] = den_q[i-1];
			src_quo[i] = quo_q[i-1];
		end
		for (int i = 0; i < Q_W; i++) begin
			take = src_rem[i] >= {1'b0, src_den[i]};
			diff = take ? src_rem[i] - {1'b0, src_den[i]} : src_rem[i];
			// remainder stays below den, so the shift cannot overflow
			nxt_rem[i] = {diff[NUM_W-1:0], 1'b0};
			nxt_quo[i] = {src_quo[i][Q_W-2:0], take};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			for (int i = 0; i < Q_W; i++) begin
				rem_q[i] <= nxt_rem[i];
				den_q[i] <= src_den[i];
				quo_q[i] <= nxt_quo[i];
			end
		end
	end

	assign quo = quo_q[Q_W-1];

endmodule

@@ design/damped_spring_force_2d_top.sv @@
// damped spring force between two point masses, fixed point with FRAC_BITS fraction bits (Q16.16 by default)
// pipeline: 3 front stages, 33 square root stages, FRAC_BITS + 1 divider stages,
// 10 force stages; throughput one word per cycle, except that the whole pipeline holds
// while the output register waits on result.ready
// arst_n clears all valid bits and loads the register defaults (k = 1.0, L = 1.0, c = 0)
// depends on dsf_pkg, dsf_if, dsf_dly, dsf_mul, dsf_sqrt, dsf_div
module damped_spring_force_2d_top #(
	parameter int FRAC_BITS = dsf_pkg::FRAC_BITS
) (
	input  logic                clk,
	input  logic                arst_n,
	dsf_cfg_if.sink             cfg,
	dsf_item_if.sink            item,
	dsf_result_if.source        result
);

	localparam int D_W    = dsf_pkg::DIFF_W;       // position / velocity differences
	localparam int K_W    = dsf_pkg::REG_W;
	localparam int O_W    = dsf_pkg::POS_W;
	localparam int RAD_W  = 2 * D_W;               // dx^2 + dy^2
	localparam int SQ_N   = D_W;                   // square root stages
	localparam int Q_W    = FRAC_BITS + 1;         // unit vector magnitude, at most 1.0
	localparam int DIV_N  = Q_W;                   // divider stages
	localparam int T_D    = 3 + SQ_N;              // stage where d is ready
	localparam int T_Q    = T_D + DIV_N;           // stage where the unit vector is ready
	localparam int LAT    = T_Q + 10;
	localparam int FS_W   = 65 - FRAC_BITS;        // signed k*(d-L)
	localparam int FD_W   = 66 - FRAC_BITS;        // signed c*dot
	localparam int T_W    = 67 - FRAC_BITS;        // signed total axial force
	localparam int E_W    = FRAC_BITS + 34;        // clamped (d-L)^2
	localparam int PX_W   = FRAC_BITS + 35;
	localparam int P_W    = FRAC_BITS + 36;
	localparam int DOT_W  = 34;
	localparam int TX_W   = Q_W + T_W - 1;
	localparam int M_W    = TX_W - FRAC_BITS;

	localparam logic [65:0] E_CAP = 66'(1) << (FRAC_BITS + 33);

	function automatic logic [D_W-1:0] mag_of(input logic signed [D_W-1:0] v);
		logic [D_W-1:0] r;
		r = v[D_W-1] ? D_W'(-v) : D_W'(v);
		return r;
	endfunction

	// ------------------------------------------------------------------
	// configuration registers, index 3 is ignored
	// ------------------------------------------------------------------
	logic [K_W-1:0] stiff_q, rest_q, damp_q;

	assign cfg.ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			stiff_q <= dsf_pkg::RST_STIFFNESS;
			rest_q  <= dsf_pkg::RST_REST_LENGTH;
			damp_q  <= dsf_pkg::RST_DAMPING;
		end else if (cfg.valid) begin
			unique case (cfg.index)
				dsf_pkg::IDX_STIFFNESS:   stiff_q <= cfg.data[K_W-1:0];
				dsf_pkg::IDX_REST_LENGTH: rest_q  <= cfg.data[K_W-1:0];
				dsf_pkg::IDX_DAMPING:     damp_q  <= cfg.data[K_W-1:0];
				default: ;
			endcase
		end
	end

	// ------------------------------------------------------------------
	// pipeline control: one enable for every stage, valid bits shift with it
	// ------------------------------------------------------------------
	logic           en;
	logic [LAT:1]   vld_q;

	assign en         = !vld_q[LAT] || result.ready;
	assign item.ready = en;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vld_q <= '0;
		end else if (en) begin
			vld_q <= {vld_q[LAT-1:1], item.valid};
		end
	end

	// ------------------------------------------------------------------
	// front: differences, squares, radicand
	// ------------------------------------------------------------------
	logic signed [D_W-1:0] dx_s1, dy_s1, rvx_s1, rvy_s1;
	logic [D_W-1:0]        mdx_f, mdy_f;
	logic [2*O_W-1:0]      sqx_s2, sqy_s2;
	logic                  hx_s2, hy_s2;
	logic [RAD_W-1:0]      rad_s3;

	assign mdx_f = mag_of(dx_s1);
	assign mdy_f = mag_of(dy_s1);

	always_ff @(posedge clk) begin
		if (en) begin
			dx_s1  <= D_W'(item.data.b_pos_x) - D_W'(item.data.a_pos_x);
			dy_s1  <= D_W'(item.data.b_pos_y) - D_W'(item.data.a_pos_y);
			rvx_s1 <= D_W'(item.data.b_vel_x) - D_W'(item.data.a_vel_x);
			rvy_s1 <= D_W'(item.data.b_vel_y) - D_W'(item.data.a_vel_y);
			// a magnitude of 2^32 has a zero low word, so its square is {1, 0}
			sqx_s2 <= (2*O_W)'(mdx_f[O_W-1:0]) * (2*O_W)'(mdx_f[O_W-1:0]);
			sqy_s2 <= (2*O_W)'(mdy_f[O_W-1:0]) * (2*O_W)'(mdy_f[O_W-1:0]);
			hx_s2  <= mdx_f[D_W-1];
			hy_s2  <= mdy_f[D_W-1];
			rad_s3 <= RAD_W'({hx_s2, sqx_s2}) + RAD_W'({hy_s2, sqy_s2});
		end
	end

	// distance, ready at stage T_D
	logic [D_W-1:0] d_w;

	dsf_sqrt #(.RAD_W(RAD_W)) u_sqrt (
		.clk  (clk),
		.en   (en),
		.rad  (rad_s3),
		.root (d_w)
	);

	// differences carried alongside the square root
	logic [4*D_W-1:0]      side1_w;
	logic signed [D_W-1:0] dxa_w, dya_w, rvxa_w, rvya_w;

	dsf_dly #(.W(4*D_W), .N(T_D-1)) u_dly_side1 (
		.clk (clk),
		.en  (en),
		.d   ({dx_s1, dy_s1, rvx_s1, rvy_s1}),
		.q   (side1_w)
	);

	assign {dxa_w, dya_w, rvxa_w, rvya_w} = side1_w;

	// ------------------------------------------------------------------
	// unit direction: |dx| * 2^F / d per axis
	// ------------------------------------------------------------------
	logic [Q_W-1:0] qx_w, qy_w;

	dsf_div #(.NUM_W(D_W), .Q_W(Q_W)) u_div_x (
		.clk (clk),
		.en  (en),
		.num (mag_of(dxa_w)),
		.den (d_w),
		.quo (qx_w)
	);

	dsf_div #(.NUM_W(D_W), .Q_W(Q_W)) u_div_y (
		.clk (clk),
		.en  (en),
		.num (mag_of(dya_w)),
		.den (d_w),
		.quo (qy_w)
	);

	logic [2*D_W+1:0]      side2_w;
	logic                  sx_w, sy_w;
	logic signed [D_W-1:0] rvxq_w, rvyq_w;

	dsf_dly #(.W(2*D_W+2), .N(DIV_N)) u_dly_side2 (
		.clk (clk),
		.en  (en),
		.d   ({dxa_w[D_W-1], dya_w[D_W-1], rvxa_w, rvya_w}),
		.q   (side2_w)
	);

	assign {sx_w, sy_w, rvxq_w, rvyq_w} = side2_w;

	// coincident flag rides along to the output stage
	logic coinc_w;

	dsf_dly #(.W(1), .N(DIV_N+9)) u_dly_coinc (
		.clk (clk),
		.en  (en),
		.d   (d_w == '0),
		.q   (coinc_w)
	);

	// ------------------------------------------------------------------
	// spring path, in parallel with the divider: stretch, k*s, energy
	// ------------------------------------------------------------------
	logic signed [D_W+1:0] s_f;
	logic [D_W-1:0]        sp_smag_s1;
	logic                  sp_sneg_s1, sp_sneg_s2, sp_sneg_s3;
	logic [63:0]           ks_w;
	logic [RAD_W-1:0]      ss_w;
	logic [65:0]           e1_f;
	logic signed [FS_W-1:0] sp_fs_s4;
	logic [E_W-1:0]        sp_e1c_s4;
	logic [K_W+E_W-1:0]    ke_w;
	logic [K_W+E_W-1:0]    esh_f;
	logic [O_W-1:0]        sp_energy_s7;

	assign s_f   = (D_W+2)'(d_w) - (D_W+2)'(rest_q);
	assign e1_f  = ss_w >> FRAC_BITS;
	assign esh_f = ke_w >> (FRAC_BITS + 1);

	always_ff @(posedge clk) begin
		if (en) begin
			sp_smag_s1 <= s_f[D_W+1] ? D_W'(-s_f) : D_W'(s_f);
			sp_sneg_s1 <= s_f[D_W+1];
			sp_sneg_s2 <= sp_sneg_s1;
			sp_sneg_s3 <= sp_sneg_s2;
			sp_fs_s4   <= sp_sneg_s3 ? -FS_W'({1'b0, ks_w[63:FRAC_BITS]})
			                         :  FS_W'({1'b0, ks_w[63:FRAC_BITS]});
			// past 2^(F+33) the energy saturates for any nonzero k
			sp_e1c_s4  <= (e1_f >= E_CAP) ? E_W'(E_CAP) : E_W'(e1_f);
			sp_energy_s7 <= (esh_f[K_W+E_W-1:O_W] != '0) ? '1 : esh_f[O_W-1:0];
		end
	end

	dsf_mul #(.AW(K_W), .BW(D_W)) u_mul_ks (
		.clk (clk), .en (en), .a (stiff_q), .b (sp_smag_s1), .p (ks_w)
	);

	dsf_mul #(.AW(D_W), .BW(D_W)) u_mul_ss (
		.clk (clk), .en (en), .a (sp_smag_s1), .b (sp_smag_s1), .p (ss_w)
	);

	dsf_mul #(.AW(K_W), .BW(E_W)) u_mul_ke (
		.clk (clk), .en (en), .a (stiff_q), .b (sp_e1c_s4), .p (ke_w)
	);

	logic signed [FS_W-1:0] fs_w;
	logic [O_W-1:0]         energy_w;

	dsf_dly #(.W(FS_W), .N(DIV_N+2)) u_dly_fs (
		.clk (clk), .en (en), .d (sp_fs_s4), .q (fs_w)
	);

	dsf_dly #(.W(O_W), .N(DIV_N+2)) u_dly_energy (
		.clk (clk), .en (en), .d (sp_energy_s7), .q (energy_w)
	);

	// ------------------------------------------------------------------
	// force path, stages counted from the divider output
	// ------------------------------------------------------------------
	logic signed [Q_W:0]    ux_f, uy_f;
	logic signed [PX_W-1:0] fc_px_s1, fc_py_s1;
	logic signed [P_W-1:0]  fc_p_s2;
	logic [P_W-1:0]         pmag_f;
	logic [DOT_W-1:0]       fc_dmag_s3;
	logic                   fc_dneg_s3, fc_dneg_s4, fc_dneg_s5;
	logic [K_W+DOT_W-1:0]   cd_w;
	logic signed [FD_W-1:0] fc_fd_s6;
	logic signed [T_W-1:0]  fc_t_s7;
	logic [T_W-2:0]         tmag_f;

	// a zero component counts as non-negative in the sign of the product
	assign ux_f   = sx_w ? -(Q_W+1)'({1'b0, qx_w}) : (Q_W+1)'({1'b0, qx_w});
	assign uy_f   = sy_w ? -(Q_W+1)'({1'b0, qy_w}) : (Q_W+1)'({1'b0, qy_w});
	assign pmag_f = fc_p_s2[P_W-1] ? P_W'(-fc_p_s2) : P_W'(fc_p_s2);
	assign tmag_f = fc_t_s7[T_W-1] ? (T_W-1)'(-fc_t_s7) : (T_W-1)'(fc_t_s7);

	always_ff @(posedge clk) begin
		if (en) begin
			fc_px_s1   <= PX_W'(ux_f) * PX_W'(rvxq_w);
			fc_py_s1   <= PX_W'(uy_f) * PX_W'(rvyq_w);
			fc_p_s2    <= P_W'(fc_px_s1) + P_W'(fc_py_s1);
			fc_dmag_s3 <= pmag_f[FRAC_BITS+DOT_W-1:FRAC_BITS];
			fc_dneg_s3 <= fc_p_s2[P_W-1];
			fc_dneg_s4 <= fc_dneg_s3;
			fc_dneg_s5 <= fc_dneg_s4;
			fc_fd_s6   <= fc_dneg_s5 ? -FD_W'({1'b0, cd_w[K_W+DOT_W-1:FRAC_BITS]})
			                         :  FD_W'({1'b0, cd_w[K_W+DOT_W-1:FRAC_BITS]});
			fc_t_s7    <= T_W'(fs_w) + T_W'(fc_fd_s6);
		end
	end

	dsf_mul #(.AW(K_W), .BW(DOT_W)) u_mul_cd (
		.clk (clk), .en (en), .a (damp_q), .b (fc_dmag_s3), .p (cd_w)
	);

	// unit vector magnitudes and signs held until the axial force is known
	logic [2*Q_W+1:0] uq_w;
	logic [Q_W-1:0]   uqx_w, uqy_w;
	logic             uxneg_w, uyneg_w;

	dsf_dly #(.W(2*Q_W+2), .N(7)) u_dly_unit (
		.clk (clk),
		.en  (en),
		.d   ({qx_w, qy_w, sx_w && (qx_w != '0), sy_w && (qy_w != '0)}),
		.q   (uq_w)
	);

	assign {uqx_w, uqy_w, uxneg_w, uyneg_w} = uq_w;

	logic [TX_W-1:0] tx_w, ty_w;
	logic            fc_negx_s8, fc_negy_s8, fc_negx_s9, fc_negy_s9;

	dsf_mul #(.AW(Q_W), .BW(T_W-1)) u_mul_tx (
		.clk (clk), .en (en), .a (uqx_w), .b (tmag_f), .p (tx_w)
	);

	dsf_mul #(.AW(Q_W), .BW(T_W-1)) u_mul_ty (
		.clk (clk), .en (en), .a (uqy_w), .b (tmag_f), .p (ty_w)
	);

	always_ff @(posedge clk) begin
		if (en) begin
			fc_negx_s8 <= fc_t_s7[T_W-1] != uxneg_w;
			fc_negy_s8 <= fc_t_s7[T_W-1] != uyneg_w;
			fc_negx_s9 <= fc_negx_s8;
			fc_negy_s9 <= fc_negy_s8;
		end
	end

	// ------------------------------------------------------------------
	// output stage: scale, saturate, zero on coincidence
	// ------------------------------------------------------------------
	logic [M_W-1:0] mx_f, my_f;
	logic [O_W-1:0] fx_f, fy_f;
	dsf_pkg::result_t fc_res_s10;

	assign mx_f = tx_w[TX_W-1:FRAC_BITS];
	assign my_f = ty_w[TX_W-1:FRAC_BITS];

	always_comb begin
		// negative side reaches -2^31, positive side stops at 2^31 - 1
		if (fc_negx_s9) begin
			fx_f = (mx_f >= M_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
			                                           : -O_W'(mx_f);
		end else begin
			fx_f = (mx_f > M_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : O_W'(mx_f);
		end
		if (fc_negy_s9) begin
			fy_f = (my_f >= M_W'(33'h1_0000_0000 >> 1)) ? 32'h8000_0000
			                                           : -O_W'(my_f);
		end else begin
			fy_f = (my_f > M_W'(32'h7FFF_FFFF)) ? 32'h7FFF_FFFF : O_W'(my_f);
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			fc_res_s10.force_x          <= coinc_w ? '0 : fx_f;
			fc_res_s10.force_y          <= coinc_w ? '0 : fy_f;
			fc_res_s10.potential_energy <= energy_w;
			fc_res_s10.coincident       <= coinc_w;
		end
	end

	assign result.valid = vld_q[LAT];
	assign result.data  = fc_res_s10;

	// ------------------------------------------------------------------
	// assertions
	// ------------------------------------------------------------------
	a_stall_blocks_intake: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && !result.ready) |-> !item.ready)
		else $error("intake open while output word is stalled");

	a_coincident_zero_force: assert property (@(posedge clk) disable iff (!arst_n)
		(result.valid && result.data.coincident) |->
		(result.data.force_x == '0 && result.data.force_y == '0))
		else $error("coincident word carries a nonzero force");

	a_valid_hold: assert property (@(posedge clk) disable iff (!arst_n)
		!en |=> $stable(vld_q))
		else $error("valid bits moved while the pipeline was held");

endmodule
